/* hw/rtl/angle_trimmed_mean_adaptive_lowpass_unit_defines.svh */
// Assertion macros for the angle low-pass filter RTL.
// Included by the filter top, the only file that carries concurrent assertions; depends on nothing.
`ifndef ANGLE_TRIMMED_MEAN_ADAPTIVE_LOWPASS_UNIT_DEFINES_SVH
`define ANGLE_TRIMMED_MEAN_ADAPTIVE_LOWPASS_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define ATMAL_ASSERT_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("atmal assertion failed");

// Next-cycle implication, checked outside reset.
`define ATMAL_ASSERT_NXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("atmal assertion failed");

`endif

/* hw/rtl/atmal_pkg.sv */
// Shared widths, register indexes and divider handshake types for the
// angle low-pass filter. No dependencies.
package atmal_pkg;

  localparam int RAW_W   = 12;
  localparam int ANGLE_W = 16;
  localparam int CFG_W   = 16;
  localparam int DIV_W   = 32;
  localparam int DVS_W   = 16;
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [1:0] REG_WEIGHT_LO = 2'd0;
  localparam logic [1:0] REG_WEIGHT_HI = 2'd1;
  localparam logic [1:0] REG_STEP_LIM  = 2'd2;

  localparam logic [CFG_W-1:0] WEIGHT_LO_RST = 16'd6554;
  localparam logic [CFG_W-1:0] WEIGHT_HI_RST = 16'd52429;
  localparam logic [CFG_W-1:0] STEP_LIM_RST  = 16'd1820;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } atmal_div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quotient;
  } atmal_div_rsp_t;

endpackage

/* hw/rtl/atmal_in_if.sv */
// Input stream channel carrying one raw encoder count per beat.
// Depends on atmal_pkg.
interface atmal_in_if import atmal_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [RAW_W-1:0] raw_angle;

  modport source (output valid, output raw_angle, input ready);
  modport sink (input valid, input raw_angle, output ready);
endinterface

/* hw/rtl/atmal_out_if.sv */
// Output stream channel carrying one filtered angle per beat.
// Depends on atmal_pkg.
interface atmal_out_if import atmal_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ANGLE_W-1:0] filtered_angle;

  modport source (output valid, output filtered_angle, input ready);
  modport sink (input valid, input filtered_angle, output ready);
endinterface

/* hw/rtl/atmal_cell.sv */
// One window cell: holds a single angle sample and passes it on to its
// neighbour whenever the chain moves. Depends on atmal_pkg.
module atmal_cell import atmal_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic [ANGLE_W-1:0] sample_i,
  output logic [ANGLE_W-1:0] sample_o
);

  logic [ANGLE_W-1:0] sample_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_q <= '0;
    end else if (en_i) begin
      sample_q <= sample_i;
    end
  end

  assign sample_o = sample_q;

endmodule

/* hw/rtl/atmal_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on atmal_pkg for the request and response structs.
module atmal_div import atmal_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  atmal_div_req_t req_i,
  output atmal_div_rsp_t rsp_o
);

  localparam int CntW = $clog2(DIV_W);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DIV_W-1:0] quo_q, quo_d;
  logic [DVS_W-1:0] dvs_q, dvs_d;
  logic [DVS_W:0]   shifted;
  logic [DVS_W:0]   trial;
  logic             fits;

  always_comb begin
    shifted = {rem_q, quo_q[DIV_W-1]};
    trial   = shifted - {1'b0, dvs_q};
    fits    = shifted >= {1'b0, dvs_q};
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    dvs_d   = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = fits ? trial[DVS_W-1:0] : shifted[DVS_W-1:0];
      quo_d = {quo_q[DIV_W-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(DIV_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

/* hw/rtl/angle_trimmed_mean_adaptive_lowpass_unit.sv */
// Angle trimmed-mean filter with adaptive exponential smoothing.
// Channels: in_i takes one 12-bit raw encoder count per beat (4096 per turn);
// out_o delivers one 16-bit filtered angle per beat (65536 per turn), one
// result for every input beat, in order. The APB port holds the weight floor,
// the weight ceiling and the step limit at byte addresses 0, 4 and 8; write it
// only while the block is idle.
// Sequence: an accepted beat moves through a window scan, the trimmed sum
// and its reciprocal multiplication, the unwrap and the weight product, a
// division for the blend weight and the blend; the result is then loaded
// into the output register. The division is skipped when the step limit is
// zero. The next input beat can be accepted in the cycle after the load, so
// the block takes no new beat while one is still in progress.
// The result sits in an output register, so the next input beat is taken
// while a finished result still waits; if the receiver is still stalled when
// the following result is ready, the block holds it and stops taking input.
// Reset clears the sample window, the smoothed angle and the output valid,
// and loads the default configuration.
// Depends on atmal_pkg, atmal_in_if, atmal_out_if, atmal_cell and atmal_div.
`include "angle_trimmed_mean_adaptive_lowpass_unit_defines.svh"

module angle_trimmed_mean_adaptive_lowpass_unit import atmal_pkg::*; #(
  parameter int WINDOW = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  atmal_in_if.sink            in_i,
  atmal_out_if.source         out_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready
);

  localparam int SumW = ANGLE_W + $clog2(WINDOW);
  localparam int CntW = $clog2(WINDOW);
  // The trimmed mean divides by a constant, done as a multiplication by a
  // rounded-up reciprocal that is exact for every sum below 2**SumW.
  localparam int     MeanDiv = WINDOW - 2;
  localparam int     MeanSh  = SumW + $clog2(MeanDiv);
  localparam longint MeanRcp = ((longint'(1) << MeanSh) + longint'(MeanDiv) - 1) /
                               longint'(MeanDiv);
  localparam logic [SumW:0] MeanMul = (SumW + 1)'(MeanRcp);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SCAN  = 4'd1;
  localparam logic [3:0] S_TRIM  = 4'd2;
  localparam logic [3:0] S_MEAN  = 4'd3;
  localparam logic [3:0] S_DIFF  = 4'd4;
  localparam logic [3:0] S_PROD  = 4'd5;
  localparam logic [3:0] S_AREQ  = 4'd6;
  localparam logic [3:0] S_AWAIT = 4'd7;
  localparam logic [3:0] S_MULB  = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  // Configuration registers and APB port.
  logic [CFG_W-1:0] amin_q, amax_q, dmax_q;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      amin_q <= WEIGHT_LO_RST;
      amax_q <= WEIGHT_HI_RST;
      dmax_q <= STEP_LIM_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_WEIGHT_LO: amin_q <= pwdata[CFG_W-1:0];
        REG_WEIGHT_HI: amax_q <= pwdata[CFG_W-1:0];
        REG_STEP_LIM:  dmax_q <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_WEIGHT_LO: prdata = PDATA_W'(amin_q);
      REG_WEIGHT_HI: prdata = PDATA_W'(amax_q);
      REG_STEP_LIM:  prdata = PDATA_W'(dmax_q);
      default:       prdata = '0;
    endcase
  end

  // Sequencer and datapath registers.
  logic [3:0]          state_q, state_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [SumW-1:0]     sum_q, sum_d;
  logic [ANGLE_W-1:0]  lo_q, lo_d, hi_q, hi_d;
  logic [SumW-1:0]     trim_q, trim_d;
  logic [ANGLE_W-1:0]  nv_q, nv_d;
  logic [ANGLE_W-1:0]  cur_q, cur_d;
  logic signed [16:0]  diff_q, diff_d;
  logic [ANGLE_W-1:0]  delta_q, delta_d;
  logic [DIV_W-1:0]    prod_q, prod_d;
  logic                span_neg_q, span_neg_d;
  logic [CFG_W-1:0]    alpha_q, alpha_d;
  logic signed [33:0]  blend_q, blend_d;
  logic                out_valid_q, out_valid_d;
  logic [ANGLE_W-1:0]  out_data_q, out_data_d;

  logic                accept;
  logic                chain_en;
  logic [ANGLE_W-1:0]  head_in;
  logic [ANGLE_W-1:0]  tail_val;
  logic [ANGLE_W-1:0]  cell_val [WINDOW];
  logic                out_free;
  logic                load_out;
  logic [2*SumW:0]     mean_prod;
  logic signed [17:0]  diff_raw, diff_adj, diff_abs;
  logic signed [16:0]  span;
  logic [CFG_W-1:0]    span_mag;
  logic [CFG_W-1:0]    delta_clip;
  logic [ANGLE_W-1:0]  next_angle;
  atmal_div_req_t      div_req;
  atmal_div_rsp_t      div_rsp;

  assign in_i.ready = (state_q == S_IDLE);
  assign accept     = in_i.valid && in_i.ready;

  // Window ring: a new sample enters at the head; during the scan the ring
  // rotates once round, feeding the tail value to the accumulators.
  assign chain_en = accept || (state_q == S_SCAN);
  assign head_in  = accept ? {in_i.raw_angle, 4'b0000} : tail_val;
  assign tail_val = cell_val[WINDOW-1];

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    atmal_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (chain_en),
      .sample_i ((i == 0) ? head_in : cell_val[(i == 0) ? 0 : i - 1]),
      .sample_o (cell_val[i])
    );
  end

  atmal_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign out_free   = !out_valid_q || out_o.ready;
  assign load_out   = (state_q == S_OUT) && out_free;
  assign next_angle = cur_q + blend_q[31:16];
  assign mean_prod  = trim_q * MeanMul;

  always_comb begin
    // Unwrap the mean to within half a turn of the smoothed angle.
    diff_raw = $signed({2'b00, nv_q}) - $signed({2'b00, cur_q});
    if (diff_raw > 18'sd32768) begin
      diff_adj = diff_raw - 18'sd65536;
    end else if (diff_raw < -18'sd32768) begin
      diff_adj = diff_raw + 18'sd65536;
    end else begin
      diff_adj = diff_raw;
    end
    diff_abs   = (diff_adj < 0) ? -diff_adj : diff_adj;
    span       = $signed({1'b0, amax_q}) - $signed({1'b0, amin_q});
    span_mag   = (span < 0) ? CFG_W'(-span) : CFG_W'(span);
    delta_clip = (delta_q > dmax_q) ? dmax_q : delta_q;
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    sum_d       = sum_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    trim_d      = trim_q;
    nv_d        = nv_q;
    cur_d       = cur_q;
    diff_d      = diff_q;
    delta_d     = delta_q;
    prod_d      = prod_q;
    span_neg_d  = span_neg_q;
    alpha_d     = alpha_q;
    blend_d     = blend_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_data_d  = out_data_q;
    div_req.start    = 1'b0;
    div_req.dividend = prod_q;
    div_req.divisor  = dmax_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cnt_d   = '0;
          sum_d   = '0;
          lo_d    = '1;
          hi_d    = '0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        sum_d = sum_q + SumW'(tail_val);
        lo_d  = (tail_val < lo_q) ? tail_val : lo_q;
        hi_d  = (tail_val > hi_q) ? tail_val : hi_q;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(WINDOW - 1)) begin
          state_d = S_TRIM;
        end
      end
      S_TRIM: begin
        trim_d  = sum_q - SumW'(lo_q) - SumW'(hi_q);
        state_d = S_MEAN;
      end
      S_MEAN: begin
        nv_d    = mean_prod[MeanSh +: ANGLE_W];
        state_d = S_DIFF;
      end
      S_DIFF: begin
        diff_d  = diff_adj[16:0];
        delta_d = diff_abs[ANGLE_W-1:0];
        state_d = S_PROD;
      end
      S_PROD: begin
        if (dmax_q == '0) begin
          // Every change has reached the limit.
          alpha_d = amax_q;
          state_d = S_MULB;
        end else begin
          prod_d     = span_mag * delta_clip;
          span_neg_d = (span < 0);
          state_d    = S_AREQ;
        end
      end
      S_AREQ: begin
        div_req.start = 1'b1;
        state_d       = S_AWAIT;
      end
      S_AWAIT: begin
        if (div_rsp.done) begin
          alpha_d = span_neg_q ? amin_q - div_rsp.quotient[CFG_W-1:0]
                               : amin_q + div_rsp.quotient[CFG_W-1:0];
          state_d = S_MULB;
        end
      end
      S_MULB: begin
        blend_d = $signed({1'b0, alpha_q}) * diff_q;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (load_out) begin
          cur_d       = next_angle;
          out_data_d  = next_angle;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      cur_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      cur_q       <= cur_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q      <= sum_d;
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    trim_q     <= trim_d;
    nv_q       <= nv_d;
    diff_q     <= diff_d;
    delta_q    <= delta_d;
    prod_q     <= prod_d;
    span_neg_q <= span_neg_d;
    alpha_q    <= alpha_d;
    blend_q    <= blend_d;
    out_data_q <= out_data_d;
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.filtered_angle = out_data_q;

  `ATMAL_ASSERT_NXT(a_accept_starts_scan, clk_i, rst_ni, accept, state_q == S_SCAN)
  `ATMAL_ASSERT_IMP(a_div_start_idle, clk_i, rst_ni, div_req.start, !div_rsp.busy)
  `ATMAL_ASSERT_IMP(a_div_done_awaited, clk_i, rst_ni, div_rsp.done, state_q == S_AWAIT)
  `ATMAL_ASSERT_NXT(a_load_shows_result, clk_i, rst_ni, load_out, out_valid_q && (state_q == S_IDLE))

endmodule

/* dv/atmal_angle_checker.sv */
// Checker for the angle low-pass filter: tracks the APB register writes, checks the reads, predicts
// every filtered angle from the accepted raw beats and compares the delivered beats in order.
// Depends on atmal_pkg, atmal_in_if and atmal_out_if.
module atmal_angle_checker import atmal_pkg::*; #(
  parameter int WINDOW = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  atmal_in_if                in_ch,
  atmal_out_if               out_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  input  logic [PDATA_W-1:0] prdata,
  output int                 pending_o,
  output int                 errors_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [CFG_W-1:0]   wlo_q;
  logic [CFG_W-1:0]   whi_q;
  logic [CFG_W-1:0]   dlim_q;
  logic [ANGLE_W-1:0] window_q [WINDOW];
  int                 slot_q;
  logic [ANGLE_W-1:0] smooth_q;
  logic [ANGLE_W-1:0] angle_exp_q [$];
  int                 mismatches = 0;
  int                 outstanding = 0;

  assign pending_o = outstanding;
  assign errors_o  = mismatches;

  task automatic report(string what, longint got, longint want);
    $display("%0t ns: mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    int                 i;
    int                 sum;
    int                 lo;
    int                 hi;
    int                 mean;
    int                 cur;
    int                 diff;
    int                 delta;
    longint             alpha;
    longint             next;
    logic [CFG_W-1:0]   reg_val;
    logic [ANGLE_W-1:0] want;
    if (!rst_ni) begin
      for (i = 0; i < WINDOW; i++) window_q[i] = '0;
      slot_q   = 0;
      smooth_q = '0;
      wlo_q    = WEIGHT_LO_RST;
      whi_q    = WEIGHT_HI_RST;
      dlim_q   = STEP_LIM_RST;
      angle_exp_q.delete();
      outstanding <= 0;
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (paddr[PADDR_W-1:2])
            REG_WEIGHT_LO: wlo_q  = pwdata[CFG_W-1:0];
            REG_WEIGHT_HI: whi_q  = pwdata[CFG_W-1:0];
            REG_STEP_LIM:  dlim_q = pwdata[CFG_W-1:0];
            default: ;
          endcase
        end else begin
          // The model has no value for the spare address, so only the three registers are checked.
          case (paddr[PADDR_W-1:2])
            REG_WEIGHT_LO: reg_val = wlo_q;
            REG_WEIGHT_HI: reg_val = whi_q;
            REG_STEP_LIM:  reg_val = dlim_q;
            default: reg_val = 'x;
          endcase
          if (!$isunknown(reg_val) && prdata !== {{(PDATA_W-CFG_W){1'b0}}, reg_val}) begin
            report($sformatf("register read at %0d", paddr), prdata, reg_val);
          end
        end
      end

      // A result can never leave in the cycle its own input beat is taken, so the oldest
      // expectation is retired before the new one is queued.
      if (out_ch.valid && out_ch.ready) begin
        if (angle_exp_q.size() == 0) begin
          report("filtered_angle, beat with nothing expected", out_ch.filtered_angle, 0);
        end else begin
          want = angle_exp_q.pop_front();
          if (out_ch.filtered_angle !== want) begin
            report("filtered_angle", out_ch.filtered_angle, want);
          end
        end
      end

      if (in_ch.valid && in_ch.ready) begin
        if (slot_q >= WINDOW) slot_q = 0;
        window_q[slot_q] = {in_ch.raw_angle, 4'b0000};
        slot_q = (slot_q + 1) % WINDOW;

        sum = 0;
        lo  = 32'h0000_FFFF;
        hi  = 0;
        for (i = 0; i < WINDOW; i++) begin
          sum += int'(window_q[i]);
          if (int'(window_q[i]) < lo) lo = int'(window_q[i]);
          if (int'(window_q[i]) > hi) hi = int'(window_q[i]);
        end
        mean = (sum - lo - hi) / (WINDOW - 2);

        // Bring the mean to within half a turn of the current estimate.
        cur = int'(smooth_q);
        if (mean - cur > 32768) mean -= 65536;
        else if (cur - mean > 32768) mean += 65536;
        diff  = mean - cur;
        delta = (diff < 0) ? -diff : diff;

        if (dlim_q == '0) begin
          alpha = longint'(whi_q);
        end else begin
          if (delta > int'(dlim_q)) delta = int'(dlim_q);
          alpha = longint'(wlo_q) +
                  ((longint'(whi_q) - longint'(wlo_q)) * longint'(delta)) /
                  longint'(dlim_q);
        end

        // Arithmetic shift floors the weighted step, negative steps included.
        next     = longint'(cur) + ((alpha * longint'(diff)) >>> 16);
        smooth_q = next[ANGLE_W-1:0];
        angle_exp_q.push_back(smooth_q);
      end
      outstanding <= angle_exp_q.size();
    end
  end

endmodule

/* dv/tb_angle_trimmed_mean_adaptive_lowpass_unit.sv */
// Top of the angle low-pass filter testbench: clock, reset, raw angle beats, output back-pressure
// and APB register settings. Depends on atmal_pkg, both channel interfaces, the block and the checker.
module tb_angle_trimmed_mean_adaptive_lowpass_unit;
  import atmal_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         WINDOW     = 8;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  logic               clk_i   = 1'b0;
  logic               rst_ni  = 1'b0;
  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [PADDR_W-1:0] paddr   = '0;
  logic [PDATA_W-1:0] pwdata  = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               sink_ready = 1'b0;
  bit                 idling = 1'b1;
  int                 walk_pos = 0;
  int                 pending;
  int                 errors;

  // Corners: both ends of the count, single steps around half a turn and across the zero
  // crossing, and alternating bit patterns.
  logic [RAW_W-1:0] corner_raw [16] = '{12'd0, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd0,
                                        12'd1, 12'd2048, 12'd2049, 12'd2047, 12'd4094, 12'd3,
                                        12'hAAA, 12'h555, 12'hFFF, 12'h000};

  atmal_in_if  in_ch ();
  atmal_out_if out_ch ();

  assign out_ch.ready = sink_ready;

  angle_trimmed_mean_adaptive_lowpass_unit #(
    .WINDOW (WINDOW)
  ) i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  atmal_angle_checker #(
    .WINDOW (WINDOW)
  ) i_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .pready    (pready),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pending_o (pending),
    .errors_o  (errors)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    sink_ready <= !idling || ($urandom_range(0, 99) >= 19);
  end

  task automatic apb_access(logic write, logic [1:0] idx, logic [PDATA_W-1:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Upper data bits are random to show that only the low half of each word is kept.
  task automatic apply_setting(logic [CFG_W-1:0] amin, logic [CFG_W-1:0] amax,
                               logic [CFG_W-1:0] dmax);
    apb_access(1'b1, REG_WEIGHT_LO, {16'($urandom), amin});
    apb_access(1'b1, REG_WEIGHT_HI, {16'($urandom), amax});
    apb_access(1'b1, REG_STEP_LIM, {16'($urandom), dmax});
    apb_access(1'b0, REG_WEIGHT_LO, '0);
    apb_access(1'b0, REG_WEIGHT_HI, '0);
    apb_access(1'b0, REG_STEP_LIM, '0);
  endtask

  task automatic wait_drained();
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Valid is only lowered for an idle cycle, so back-to-back beats keep it high.
  task automatic send_angle(logic [RAW_W-1:0] raw);
    while (idling && $urandom_range(0, 99) < 19) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.raw_angle <= raw;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  // Mostly a noisy encoder walk that crosses zero now and then, with jumps and samples
  // clustered at the wrap point mixed in.
  task automatic run_random(int n);
    repeat (n) begin
      case ($urandom_range(0, 9))
        0: walk_pos = $urandom_range(0, 4095);
        1: walk_pos = $urandom_range(0, 1) ? $urandom_range(4064, 4095) : $urandom_range(0, 31);
        default: walk_pos = (walk_pos + $urandom_range(0, 96) - 48) & 4095;
      endcase
      send_angle(walk_pos[RAW_W-1:0]);
    end
    in_ch.valid <= 1'b0;
    wait_drained();
  endtask

  initial begin
    in_ch.valid     <= 1'b0;
    in_ch.raw_angle <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (corner_raw[k]) send_angle(corner_raw[k]);
    in_ch.valid <= 1'b0;
    wait_drained();

    run_random(150);
    apply_setting(16'd0, 16'hFFFF, 16'd1);
    run_random(100);
    // Falling weight: the ceiling lies below the floor.
    apply_setting(16'hFFFF, 16'd0, 16'd32768);
    run_random(100);
    // A zero step limit makes every change count as a full one.
    apply_setting(16'($urandom), 16'($urandom), 16'd0);
    run_random(100);
    apply_setting(16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_random(60);
    apply_setting(16'd0, 16'd0, 16'd32768);
    run_random(40);

    // A write to the spare address must leave all three registers as they were.
    apb_access(1'b1, REG_UNUSED, $urandom);
    apb_access(1'b0, REG_WEIGHT_LO, '0);
    apb_access(1'b0, REG_WEIGHT_HI, '0);
    apb_access(1'b0, REG_STEP_LIM, '0);
    apb_access(1'b0, REG_UNUSED, '0);

    idling = 1'b0;
    apply_setting(16'($urandom_range(0, 32767)), 16'($urandom_range(32768, 65535)),
                  16'($urandom_range(1, 4096)));
    run_random(200);
    idling = 1'b1;

    repeat (3) begin
      apply_setting(16'($urandom), 16'($urandom),
                    ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 4096)));
      run_random(70);
    end

    repeat (WINDOW + 100) @(posedge clk_i);
    if (errors == 0) begin
      $display("[angle_trimmed_mean_adaptive_lowpass_unit] OK");
    end else begin
      $display("[angle_trimmed_mean_adaptive_lowpass_unit] ERROR");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("[angle_trimmed_mean_adaptive_lowpass_unit] ERROR");
    $finish;
  end

endmodule
